### src/h264fua_pkg.sv
// shared types and constants of the h.264 rtp fu-a packetizer
package h264fua_pkg;

   // field widths fixed by the packet format
   localparam int BYTE_W        = 8;
   localparam int SEQ_W         = 16;
   localparam int MAX_PAYLOAD_W = 11;

   // defaults for the top level parameters
   localparam int LENGTH_BITS_DEFAULT = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // reset value of the max payload register
   localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 11'd1400;

   // nal header and fu-a header codes
   localparam logic [BYTE_W-1:0] NRI_MASK  = 8'h60;
   localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;
   localparam logic [BYTE_W-1:0] FU_A_TYPE = 8'd28;
   localparam logic [BYTE_W-1:0] FU_START  = 8'h80;
   localparam logic [BYTE_W-1:0] FU_END    = 8'h40;

   // one classified nal byte, handed from front to back
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] fu_ind;
      logic [BYTE_W-1:0] fu_hdr;
      logic [SEQ_W-1:0]  seq;
      logic              with_hdr;
      logic              first;
      logic              last;
   } entry_type;

   // output beat phases
   typedef enum logic [2:0] {
      BEAT_IND  = 3'b001,
      BEAT_HDR  = 3'b010,
      BEAT_DATA = 3'b100
   } beat_type;

endpackage

### src/h264fua_front.sv
// front end: accepts nal bytes, tracks packet state and classifies each byte
module h264fua_front #(
   parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [h264fua_pkg::MAX_PAYLOAD_W-1:0]  csr_wdata,
   input  logic                                   in_accept,
   input  logic [h264fua_pkg::BYTE_W-1:0]         in_data,
   input  logic [LENGTH_BITS-1:0]                 in_length,
   input  logic                                   in_head,
   output logic                                   push,
   output h264fua_pkg::entry_type                 push_entry
);
   import h264fua_pkg::*;

   logic [MAX_PAYLOAD_W-1:0] max_payload_ff, max_payload_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic [LENGTH_BITS-1:0]   seen_ff, seen_in;
   logic [BYTE_W-1:0]        held_ff, held_in;
   logic                     frag_ff, frag_in;
   logic [MAX_PAYLOAD_W-1:0] fill_ff, fill_in;

   logic [MAX_PAYLOAD_W-1:0] m;
   logic [LENGTH_BITS-1:0]   m_ext;
   logic [LENGTH_BITS-1:0]   len_adj;
   logic [LENGTH_BITS-1:0]   remain;
   logic [SEQ_W-1:0]         seq_cur;
   logic                     near_end;
   logic                     fill_full;
   logic                     no_nal;
   logic                     last;
   logic [BYTE_W-1:0]        fuh;

   // effective max payload, zero acts as one
   assign m     = (max_payload_ff == '0) ? MAX_PAYLOAD_W'(1) : max_payload_ff;
   assign m_ext = LENGTH_BITS'(m);

   // comparisons shared by the classification
   assign len_adj   = (in_length == '0) ? LENGTH_BITS'(1) : in_length;
   assign remain    = in_length - seen_ff;
   assign near_end  = ({1'b0, seen_ff} + (LENGTH_BITS+1)'(1)) >= {1'b0, in_length};
   assign fill_full = ({1'b0, fill_ff} + (MAX_PAYLOAD_W+1)'(1)) >= {1'b0, m};
   assign no_nal    = (seen_ff == '0) || (seen_ff >= in_length);
   assign seq_cur   = (fill_ff != '0) ? seq_ff + SEQ_W'(1) : seq_ff;

   // classification and next state
   always_comb begin
      max_payload_in = csr_we ? csr_wdata : max_payload_ff;
      seq_in  = seq_ff;
      seen_in = seen_ff;
      held_in = held_ff;
      frag_in = frag_ff;
      fill_in = fill_ff;
      push    = 1'b0;
      last    = 1'b0;
      fuh     = held_ff & TYPE_MASK;
      if (seen_ff == LENGTH_BITS'(1)) begin
         fuh = fuh | FU_START;
      end else if (remain <= m_ext) begin
         fuh = fuh | FU_END;
      end
      push_entry.data     = in_data;
      push_entry.fu_ind   = (held_ff & NRI_MASK) | FU_A_TYPE;
      push_entry.fu_hdr   = fuh;
      push_entry.seq      = seq_ff;
      push_entry.with_hdr = 1'b0;
      push_entry.first    = 1'b0;
      push_entry.last     = 1'b0;
      if (in_accept) begin
         if (in_head) begin
            seen_in = LENGTH_BITS'(1);
            fill_in = '0;
            seq_in  = seq_cur;
            if (len_adj <= m_ext) begin
               // nal fits one packet
               last             = (len_adj <= LENGTH_BITS'(1));
               frag_in          = 1'b0;
               push             = 1'b1;
               push_entry.seq   = seq_cur;
               push_entry.first = 1'b1;
               push_entry.last  = last;
               if (last) begin
                  seq_in = seq_cur + SEQ_W'(1);
               end else begin
                  fill_in = MAX_PAYLOAD_W'(1);
               end
            end else begin
               // header held back for the fu-a fragments
               frag_in = 1'b1;
               held_in = in_data;
            end
         end else if (!no_nal) begin
            push = 1'b1;
            if (!frag_ff) begin
               last             = near_end;
               push_entry.first = (fill_ff == '0);
            end else begin
               last                = fill_full || near_end;
               push_entry.with_hdr = (fill_ff == '0);
            end
            push_entry.last = last;
            if (last) begin
               seq_in  = seq_ff + SEQ_W'(1);
               fill_in = '0;
            end else begin
               fill_in = fill_ff + MAX_PAYLOAD_W'(1);
            end
            seen_in = seen_ff + LENGTH_BITS'(1);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         seq_ff         <= '0;
         seen_ff        <= '0;
         held_ff        <= '0;
         frag_ff        <= 1'b0;
         fill_ff        <= '0;
      end else begin
         max_payload_ff <= max_payload_in;
         seq_ff         <= seq_in;
         seen_ff        <= seen_in;
         held_ff        <= held_in;
         frag_ff        <= frag_in;
         fill_ff        <= fill_in;
      end
   end

endmodule

### src/h264fua_queue.sv
// short queue of classified bytes between front and back
module h264fua_queue #(
   parameter int DEPTH = h264fua_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  h264fua_pkg::entry_type  push_entry,
   input  logic                    pop,
   output logic                    full,
   output logic                    empty,
   output h264fua_pkg::entry_type  head_entry
);
   import h264fua_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign head_entry = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   // pointer and fill count update
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

### src/h264fua_back.sv
// back end: expands each queued byte into one or three output beats
module h264fua_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 empty,
   input  h264fua_pkg::entry_type               head_entry,
   output logic                                 pop,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [h264fua_pkg::BYTE_W-1:0]       out_data,
   output logic [h264fua_pkg::SEQ_W-1:0]        out_seq,
   output logic                                 out_first,
   output logic                                 out_last_pkt,
   output logic                                 out_last_run
);
   import h264fua_pkg::*;

   beat_type beat_ff, beat_in;
   beat_type phase;
   logic     fire;

   // entries without fu-a headers go straight to the data beat
   assign phase     = head_entry.with_hdr ? beat_ff : BEAT_DATA;
   assign out_valid = !empty;
   assign fire      = out_valid && out_ready;
   assign out_seq   = head_entry.seq;

   // beat payload
   always_comb begin
      out_data     = head_entry.data;
      out_first    = 1'b0;
      out_last_pkt = 1'b0;
      out_last_run = 1'b0;
      pop          = 1'b0;
      beat_in      = beat_ff;
      unique case (phase)
         BEAT_IND: begin
            out_data  = head_entry.fu_ind;
            out_first = 1'b1;
            if (fire) begin
               beat_in = BEAT_HDR;
            end
         end
         BEAT_HDR: begin
            out_data = head_entry.fu_hdr;
            if (fire) begin
               beat_in = BEAT_DATA;
            end
         end
         BEAT_DATA: begin
            out_data     = head_entry.data;
            out_first    = head_entry.first;
            out_last_pkt = head_entry.last;
            out_last_run = 1'b1;
            if (fire) begin
               beat_in = BEAT_IND;
               pop     = 1'b1;
            end
         end
         default: begin
            beat_in = BEAT_IND;
         end
      endcase
   end

   // beat phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= BEAT_IND;
      end else begin
         beat_ff <= beat_in;
      end
   end

endmodule

### src/h264_rtp_fua_packetizer.sv
// top level of the h.264 rtp fu-a packetizer
//
// channel   direction  fields
// req_      in         tdata: data_in, nal_length; tuser: first_of_nal
// rsp_      out        tdata: data_out, packet_seq; tuser: first/last_in_packet; tlast
// csr_      in         wdata: max_payload (written when csr_we is high)
//
// the front takes one nal byte per cycle; each byte gives zero, one or three
// output beats, three on the first byte of every fu-a fragment (the back emits
// one beat per cycle while rsp_tready is high).
// a queue of QUEUE_DEPTH entries lets the front keep accepting while the back
// stalls; req_tready falls only when the queue is full.
// synchronous reset clears all state and the queue and loads max_payload 1400.
module h264_rtp_fua_packetizer #(
   parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = h264fua_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // config
   input  logic                                   csr_we,
   input  logic [h264fua_pkg::MAX_PAYLOAD_W-1:0]  csr_wdata,
   // input stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // data_in [7:0], nal_length [LENGTH_BITS+7:8], zero padding above
   input  logic [((LENGTH_BITS+15)/8)*8-1:0]      req_tdata,
   // first_of_nal [0]
   input  logic                                   req_tuser,
   // output stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // data_out [7:0], packet_seq [23:8]
   output logic [23:0]                            rsp_tdata,
   // first_in_packet [0], last_in_packet [1]
   output logic [1:0]                             rsp_tuser,
   // last_of_run
   output logic                                   rsp_tlast
);
   import h264fua_pkg::*;

   entry_type          push_entry;
   entry_type          head_entry;
   logic               push;
   logic               pop;
   logic               full;
   logic               empty;
   logic               in_accept;
   logic [BYTE_W-1:0]  out_data;
   logic [SEQ_W-1:0]   out_seq;
   logic               out_first;
   logic               out_last_pkt;

   assign req_tready = !full;
   assign in_accept  = req_tvalid && req_tready;

   // classification front
   h264fua_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .in_accept  (in_accept),
      .in_data    (req_tdata[BYTE_W-1:0]),
      .in_length  (req_tdata[BYTE_W+LENGTH_BITS-1:BYTE_W]),
      .in_head    (req_tuser),
      .push       (push),
      .push_entry (push_entry)
   );

   // decoupling queue
   h264fua_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head_entry (head_entry)
   );

   // beat generation back
   h264fua_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head_entry   (head_entry),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_data     (out_data),
      .out_seq      (out_seq),
      .out_first    (out_first),
      .out_last_pkt (out_last_pkt),
      .out_last_run (rsp_tlast)
   );

   // output packing
   assign rsp_tdata = {out_seq, out_data};
   assign rsp_tuser = {out_last_pkt, out_first};

endmodule

### tb/sv/h264_rtp_fua_packetizer_tb.sv
// self-checking testbench for the h.264 rtp fu-a packetizer, with its own packet predictor
module h264_rtp_fua_packetizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import h264fua_pkg::*;

   localparam int LEN_W      = LENGTH_BITS_DEFAULT;
   localparam int REQ_W      = ((LEN_W + 15) / 8) * 8;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE     = 12;

   // one expected output transaction
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [SEQ_W-1:0]  seq;
      logic              first;
      logic              last;
      logic              run_end;
   } pkt_beat_type;

   // how a stimulus row is checked
   typedef enum logic [1:0] {
      ROW_PRED,   // predicted results
      ROW_ONE,    // one result typed in the row
      ROW_NONE,   // no result at all
      ROW_CFG     // max payload write
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic [BYTE_W-1:0]        data;
      logic [LEN_W-1:0]         len;
      logic                     head;
      logic [MAX_PAYLOAD_W-1:0] cfg;
      pkt_beat_type             beat;
   } stim_row_type;

   localparam pkt_beat_type NO_BEAT = '0;
   localparam int           N_ROWS  = 28;

   // directed rows, starting from the reset max payload of 1400
   localparam stim_row_type DIRECTED [N_ROWS] = '{
      // stray byte before any header
      '{ROW_NONE, 8'hAA, 20'd5, 1'b0, 11'd0, NO_BEAT},
      // header-only unit and zero length header
      '{ROW_ONE, 8'h65, 20'd1, 1'b1, 11'd0, '{8'h65, 16'd0, 1'b1, 1'b1, 1'b1}},
      '{ROW_ONE, 8'h00, 20'd0, 1'b1, 11'd0, '{8'h00, 16'd1, 1'b1, 1'b1, 1'b1}},
      // byte past the end of the unit
      '{ROW_NONE, 8'hFF, 20'd1, 1'b0, 11'd0, NO_BEAT},
      '{ROW_ONE, 8'hFF, 20'd4, 1'b1, 11'd0, '{8'hFF, 16'd2, 1'b1, 1'b0, 1'b1}},
      '{ROW_PRED, 8'h00, 20'd4, 1'b0, 11'd0, NO_BEAT},
      // new header while a packet is open
      '{ROW_PRED, 8'h41, 20'd2, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h5A, 20'd2, 1'b0, 11'd0, NO_BEAT},
      // longest unit, fragmented, then its length changes mid unit
      '{ROW_NONE, 8'h7C, 20'hFFFFF, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h12, 20'hFFFFF, 1'b0, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h34, 20'hFFFFF, 1'b0, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h56, 20'd4, 1'b0, 11'd0, NO_BEAT},
      '{ROW_NONE, 8'h78, 20'd4, 1'b0, 11'd0, NO_BEAT},
      // exactly max payload stays single, one more fragments
      '{ROW_PRED, 8'h67, 20'd1400, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h68, 20'd1401, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h00, 20'd1401, 1'b0, 11'd0, NO_BEAT},
      // zero max payload acts as one: start, middle and end fragments
      '{ROW_CFG, 8'h00, 20'd0, 1'b0, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h7A, 20'd4, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h11, 20'd4, 1'b0, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h22, 20'd4, 1'b0, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h33, 20'd4, 1'b0, 11'd0, NO_BEAT},
      // single fragment carries only the start bit
      '{ROW_PRED, 8'hE5, 20'd2, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'hFF, 20'd2, 1'b0, 11'd0, NO_BEAT},
      // largest register value
      '{ROW_CFG, 8'h00, 20'd0, 1'b0, 11'd2047, NO_BEAT},
      '{ROW_PRED, 8'h06, 20'd2047, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h09, 20'd2047, 1'b0, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'h9F, 20'd2048, 1'b1, 11'd0, NO_BEAT},
      '{ROW_PRED, 8'hC3, 20'd2048, 1'b0, 11'd0, NO_BEAT}
   };

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [MAX_PAYLOAD_W-1:0] csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_W-1:0]         req_tdata;   // data_in [7:0], nal_length [27:8]
   logic                     req_tuser;   // first_of_nal [0]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [23:0]              rsp_tdata;   // data_out [7:0], packet_seq [23:8]
   logic [1:0]               rsp_tuser;   // first_in_packet [0], last_in_packet [1]
   logic                     rsp_tlast;

   // predictor state
   logic [MAX_PAYLOAD_W-1:0] max_payload;
   logic [SEQ_W-1:0]         seq_cnt;
   logic [LEN_W-1:0]         nal_pos;
   logic [BYTE_W-1:0]        fu_src_hdr;
   logic                     frag_mode;
   logic [MAX_PAYLOAD_W-1:0] pkt_fill;

   pkt_beat_type step_out [$];
   pkt_beat_type expected_beats [$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   bit           quiet = 1'b0;

   h264_rtp_fua_packetizer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic void emit_beat(input logic [BYTE_W-1:0] b, input logic first,
                                     input logic last);
      step_out.push_back('{b, seq_cnt, first, last, 1'b0});
   endfunction

   function automatic void end_packet();
      seq_cnt  = seq_cnt + 1'b1;
      pkt_fill = '0;
   endfunction

   // expected packet bytes for one nal byte; ignored is set when state is untouched
   function automatic void predict_nal_byte(input logic [BYTE_W-1:0] b,
                                            input logic [LEN_W-1:0] len_in,
                                            input logic head, output bit ignored);
      int unsigned       m;
      int unsigned       len;
      int unsigned       p;
      int unsigned       total;
      logic              last;
      logic [BYTE_W-1:0] fuh;
      step_out.delete();
      ignored = 1'b0;
      m   = (max_payload == '0) ? 1 : 32'(max_payload);
      len = 32'(len_in);
      if (head) begin
         if (len == 0) len = 1;
         if (pkt_fill != '0) end_packet();
         pkt_fill = '0;
         nal_pos  = LEN_W'(1);
         if (len <= m) begin
            frag_mode = 1'b0;
            last = (len <= 1);
            emit_beat(b, 1'b1, last);
            if (last) end_packet();
            else pkt_fill = MAX_PAYLOAD_W'(1);
         end else begin
            frag_mode  = 1'b1;
            fu_src_hdr = b;
         end
      end else begin
         if (nal_pos == '0 || 32'(nal_pos) >= len) begin
            ignored = 1'b1;
            return;
         end
         p     = 32'(nal_pos) - 1;
         total = len - 1;
         if (!frag_mode) begin
            last = (32'(nal_pos) + 1 >= len);
            emit_beat(b, pkt_fill == '0, last);
         end else begin
            // fragment opens with fu indicator and fu header
            if (pkt_fill == '0) begin
               fuh = fu_src_hdr & TYPE_MASK;
               if (p == 0) fuh = fuh | FU_START;
               else if (total - p <= m) fuh = fuh | FU_END;
               emit_beat((fu_src_hdr & NRI_MASK) | FU_A_TYPE, 1'b1, 1'b0);
               emit_beat(fuh, 1'b0, 1'b0);
            end
            last = (32'(pkt_fill) + 1 >= m) || (p + 1 >= total);
            emit_beat(b, 1'b0, last);
         end
         if (last) end_packet();
         else pkt_fill = pkt_fill + 1'b1;
         nal_pos = nal_pos + 1'b1;
      end
      if (step_out.size() > 0) step_out[$].run_end = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // send one nal byte, with a random gap first unless quiet
   task automatic send_nal_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] len,
                                input logic head, input row_kind_type how,
                                input pkt_beat_type typed, output bit ignored);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      predict_nal_byte(b, len, head, ignored);
      case (how)
         ROW_PRED: foreach (step_out[i]) expected_beats.push_back(step_out[i]);
         ROW_ONE:  expected_beats.push_back(typed);
         default: ;
      endcase
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({len, b});
      req_tuser  <= head;
      do @(posedge clock); while (!req_tready);
   endtask

   // register write once every expected transaction is out and the queue has settled
   task automatic write_max_payload(input logic [MAX_PAYLOAD_W-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we      <= 1'b0;
      max_payload = value;
   endtask

   // random nal units, mostly well formed, some truncated, stray or length-changing
   task automatic random_nals(input int budget);
      int unsigned      m;
      int unsigned      len;
      int unsigned      nbytes;
      int unsigned      pick;
      int               sent;
      bit               ign;
      logic [LEN_W-1:0] blen;
      sent = 0;
      m = (max_payload == '0) ? 1 : 32'(max_payload);
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_nal_byte(8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 20'hFFFFF)),
                          1'b0, ROW_PRED, NO_BEAT, ign);
            sent++;
         end else begin
            if (pick < 12) len = 0;
            else if (pick < 20) len = $urandom_range(1, 20'hFFFFF);
            else if (m <= 64) len = $urandom_range(1, 3 * m + 3);
            else if ($urandom_range(0, 3) == 0) len = $urandom_range(m - 2, m + 3);
            else len = $urandom_range(1, 48);
            nbytes = (len == 0) ? 1 : len;
            // long units, and some others at random, are cut short and abandoned by the next header
            if (nbytes > 80 || $urandom_range(0, 9) == 0)
               nbytes = $urandom_range(1, (nbytes > 40) ? 40 : nbytes);
            send_nal_byte(8'($urandom_range(0, 255)), LEN_W'(len), 1'b1, ROW_PRED,
                          NO_BEAT, ign);
            sent++;
            for (int unsigned i = 1; i < nbytes && sent < budget; i++) begin
               blen = LEN_W'(len);
               if ($urandom_range(0, 49) == 0) blen = LEN_W'($urandom_range(1, len + 2));
               send_nal_byte(8'($urandom_range(0, 255)), blen, 1'b0, ROW_PRED, NO_BEAT, ign);
               sent++;
            end
         end
      end
   endtask

   // output side stalls in short bursts
   always @(posedge clock) begin : drive_rsp_ready
      int stall_left;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each output transaction with the oldest expectation
   always @(posedge clock) begin : check_beats
      pkt_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_tdata), 32'd0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_tdata[7:0] !== want.data)
               report_mismatch("data_out", 32'(rsp_tdata[7:0]), 32'(want.data));
            if (rsp_tdata[23:8] !== want.seq)
               report_mismatch("packet_seq", 32'(rsp_tdata[23:8]), 32'(want.seq));
            if (rsp_tuser[0] !== want.first)
               report_mismatch("first_in_packet", 32'(rsp_tuser[0]), 32'(want.first));
            if (rsp_tuser[1] !== want.last)
               report_mismatch("last_in_packet", 32'(rsp_tuser[1]), 32'(want.last));
            if (rsp_tlast !== want.run_end)
               report_mismatch("last_of_run", 32'(rsp_tlast), 32'(want.run_end));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // reset, directed rows, random phases, drain
   initial begin
      int unsigned  phase_cfg [7];
      bit           ign;
      stim_row_type row;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      max_payload = MAX_PAYLOAD_RESET;
      seq_cnt     = '0;
      nal_pos     = '0;
      fu_src_hdr  = '0;
      frag_mode   = 1'b0;
      pkt_fill    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         if (row.kind == ROW_CFG) write_max_payload(row.cfg);
         else send_nal_byte(row.data, row.len, row.head, row.kind, row.beat, ign);
      end

      phase_cfg = '{16, 1500, 0, 2047, 1, 0, 24};
      phase_cfg[5] = $urandom_range(17, 48);
      foreach (phase_cfg[p]) begin
         write_max_payload(MAX_PAYLOAD_W'(phase_cfg[p]));
         if (p == 6) quiet = 1'b1;
         random_nals(62);
      end

      req_tvalid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (2 * SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
src/h264fua_pkg.sv
src/h264fua_front.sv
src/h264fua_queue.sv
src/h264fua_back.sv
src/h264_rtp_fua_packetizer.sv
tb/sv/h264_rtp_fua_packetizer_tb.sv
